### hdl/assert_macros.svh
// Assertion macros used by the top level of the joint angle fusion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk while reset is released.
`define DPJAF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset cycles included.
`define DPJAF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### hdl/dpjaf_pkg.sv
// Types and constants shared by the joint angle fusion modules.
package dpjaf_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ZERO_A     = 2'd0,
        CFG_ZERO_B     = 2'd1,
        CFG_JOINT_KIND = 2'd2
    } cfg_idx_t;

    // Joint scaling selection.
    typedef enum logic {
        JOINT_SHOULDER = 1'b0,
        JOINT_ELBOW    = 1'b1
    } joint_t;

    // Which potentiometer an angle unit serves; B runs with the opposite sign.
    typedef enum logic {
        SENSOR_A = 1'b0,
        SENSOR_B = 1'b1
    } sensor_t;

    // Sensor angle in degrees after the single wrap, range -151..360.
    typedef logic signed [9:0] angle_t;

    // Per-sensor result handed from an angle unit to the fusion logic.
    typedef struct packed {
        logic   dead;
        angle_t angle;
    } sensor_status_t;

    // Degrees per top-byte count is 131/100.
    localparam int SCALE_NUM    = 131;
    localparam int SCALE_DEN    = 100;
    // floor(n/100) = (n * 5243) >> 19, exact for n below 43699.
    localparam int DIV100_RECIP = 5243;
    localparam int DIV100_SHIFT = 19;
    // Combined constants: floor(131*v/100) and ceil(131*v/100).
    localparam int QUO_RECIP    = SCALE_NUM * DIV100_RECIP;
    localparam int QUO_CEIL_ADD = (SCALE_DEN - 1) * DIV100_RECIP;

    // Dead zone limits on the top byte of a sample.
    localparam logic [7:0] DEAD_LOW  = 8'd10;
    localparam logic [7:0] DEAD_HIGH = 8'd245;

    // Wrap handling.
    localparam logic signed [10:0] FULL_TURN = 11'sd360;
    localparam angle_t WRAP_LOW  = 10'sd4;
    localparam angle_t WRAP_HIGH = 10'sd356;
    localparam logic signed [10:0] MAX_DIFF = 11'sd8;

    // Output codes and joint limits.
    localparam logic [11:0] DISAGREE_CODE = 12'hFFF;
    localparam logic [11:0] SHOULDER_MAX  = 12'd164;
    localparam logic [11:0] ELBOW_MAX     = 12'd240;

    // floor(16*p/35) = (p * 16 * 7490) >> 18 for p up to 360.
    localparam int SHOULDER_RECIP = 16 * 7490;
    localparam int SHOULDER_SHIFT = 18;
    // floor(2*p/3) = (p * 2 * 21846) >> 16 for p up to 360.
    localparam int ELBOW_RECIP    = 2 * 21846;
    localparam int ELBOW_SHIFT    = 16;

endpackage

### hdl/dual_pot_joint_angle_fusion.sv
// Top level of the dual potentiometer joint angle fusion block.
//
//  Channel   Direction  Transaction carries
//  s_axis    in         sample_a, sample_b (one sample pair)
//  m_axis    out        angle_code (joint angle, 4095 when the sensors disagree)
//  cfg       in         cfg_index, cfg_data (one register write)
//
// One sample pair is accepted per cycle while s_axis_tready is high. The input,
// fusion and scaling registers sit in series, so a result is offered on m_axis
// once its pair has passed through each of them in turn.
// Each stage advances when the stage after it is empty or moving, so a stalled
// m_axis holds the pipeline and s_axis keeps accepting while bubbles remain.
// aresetn is synchronous and active low; it empties the pipeline and clears
// the registers to zero offsets and shoulder scaling. cfg_ready is always high.
`include "assert_macros.svh"

module dual_pot_joint_angle_fusion #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_axis_tdata: sample_a [SAMPLE_BITS-1:0], sample_b next, zero fill above
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // m_axis_tdata: angle_code [11:0], zero fill [15:12]
    output logic [15:0]                           m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [8:0]                            cfg_data
);

    // Configuration registers.
    logic [8:0]          zero_a_reg;
    logic [8:0]          zero_b_reg;
    dpjaf_pkg::joint_t   kind_reg;

    // Pipeline registers.
    logic                in_vld_reg;
    logic [7:0]          va_reg;
    logic [7:0]          vb_reg;
    logic                mid_vld_reg;
    dpjaf_pkg::angle_t   mid_pot_reg;
    dpjaf_pkg::angle_t   mid_pot_next;
    logic                mid_bad_reg;
    logic                mid_bad_next;
    logic                out_vld_reg;
    logic [11:0]         out_angle_reg;
    logic [11:0]         out_angle_next;

    logic                in_adv;
    logic                mid_adv;
    logic                out_adv;

    dpjaf_pkg::sensor_status_t st_a;
    dpjaf_pkg::sensor_status_t st_b;
    logic signed [10:0]  diff;
    logic signed [10:0]  sum;
    logic [8:0]          pot_mag;
    logic [25:0]         sh_prod;
    logic [24:0]         el_prod;
    logic [11:0]         sh_joint;
    logic [11:0]         el_joint;

    // Stage advance chain.
    assign out_adv       = !out_vld_reg || m_axis_tready;
    assign mid_adv       = !mid_vld_reg || out_adv;
    assign in_adv        = !in_vld_reg || mid_adv;
    assign s_axis_tready = in_adv;
    assign cfg_ready     = 1'b1;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_a_reg <= '0;
            zero_b_reg <= '0;
            kind_reg   <= dpjaf_pkg::JOINT_SHOULDER;
        end else if (cfg_valid) begin
            unique case (dpjaf_pkg::cfg_idx_t'(cfg_index))
                dpjaf_pkg::CFG_ZERO_A:     zero_a_reg <= cfg_data;
                dpjaf_pkg::CFG_ZERO_B:     zero_b_reg <= cfg_data;
                dpjaf_pkg::CFG_JOINT_KIND: kind_reg   <= dpjaf_pkg::joint_t'(cfg_data[0]);
                default: begin
                end
            endcase
        end
    end

    // Input stage keeps the top byte of each sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_adv) begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_axis_tvalid) begin
            va_reg <= s_axis_tdata[SAMPLE_BITS-1 -: 8];
            vb_reg <= s_axis_tdata[2*SAMPLE_BITS-1 -: 8];
        end
    end

    // Sensor angles.
    dpjaf_angle u_angle_a (
        .side        (dpjaf_pkg::SENSOR_A),
        .value       (va_reg),
        .zero_offset (zero_a_reg),
        .status      (st_a)
    );

    dpjaf_angle u_angle_b (
        .side        (dpjaf_pkg::SENSOR_B),
        .value       (vb_reg),
        .zero_offset (zero_b_reg),
        .status      (st_b)
    );

    // Fusion of the two angles into one pot angle.
    assign diff = 11'(st_a.angle) - 11'(st_b.angle);
    assign sum  = 11'(st_a.angle) + 11'(st_b.angle);

    always_comb begin
        mid_pot_next = st_b.angle;
        mid_bad_next = 1'b0;
        priority if (st_a.dead) begin
            mid_pot_next = st_b.angle;
        end else if (st_b.dead) begin
            mid_pot_next = st_a.angle;
        end else if (st_a.angle < dpjaf_pkg::WRAP_LOW && st_b.angle > dpjaf_pkg::WRAP_HIGH) begin
            mid_pot_next = st_a.angle;
        end else if (st_b.angle < dpjaf_pkg::WRAP_LOW && st_a.angle > dpjaf_pkg::WRAP_HIGH) begin
            mid_pot_next = st_b.angle;
        end else if (diff > dpjaf_pkg::MAX_DIFF || diff < -dpjaf_pkg::MAX_DIFF) begin
            mid_bad_next = 1'b1;
        end else begin
            // A negative sum rounds the other way here, but it ends at zero anyway.
            mid_pot_next = sum[10:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_vld_reg <= 1'b0;
        end else if (mid_adv) begin
            mid_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_adv && in_vld_reg) begin
            mid_pot_reg <= mid_pot_next;
            mid_bad_reg <= mid_bad_next;
        end
    end

    // Joint scaling with reciprocal multiplies.
    assign pot_mag  = mid_pot_reg[8:0];
    assign sh_prod  = 26'(pot_mag) * 26'(dpjaf_pkg::SHOULDER_RECIP);
    assign el_prod  = 25'(pot_mag) * 25'(dpjaf_pkg::ELBOW_RECIP);
    assign sh_joint = 12'(sh_prod[25:dpjaf_pkg::SHOULDER_SHIFT]);
    assign el_joint = 12'(el_prod[24:dpjaf_pkg::ELBOW_SHIFT]);

    always_comb begin
        out_angle_next = '0;
        priority if (mid_bad_reg) begin
            out_angle_next = dpjaf_pkg::DISAGREE_CODE;
        end else if (mid_pot_reg <= 10'sd0) begin
            out_angle_next = '0;
        end else begin
            unique case (kind_reg)
                dpjaf_pkg::JOINT_SHOULDER: begin
                    out_angle_next = (sh_joint > dpjaf_pkg::SHOULDER_MAX) ?
                                     dpjaf_pkg::SHOULDER_MAX : sh_joint;
                end
                dpjaf_pkg::JOINT_ELBOW: begin
                    out_angle_next = (el_joint > dpjaf_pkg::ELBOW_MAX) ?
                                     dpjaf_pkg::ELBOW_MAX : el_joint;
                end
                default: begin
                    out_angle_next = '0;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_adv) begin
            out_vld_reg <= mid_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && mid_vld_reg) begin
            out_angle_reg <= out_angle_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'b0000, out_angle_reg};

    // Checks on the pipeline and the result range.
    `DPJAF_ASSERT_ALWAYS(a_reset_empties,
        (!aresetn) |=> (!in_vld_reg && !mid_vld_reg && !out_vld_reg),
        "pipeline not empty after reset")
    `DPJAF_ASSERT(a_code_range,
        out_vld_reg |-> (out_angle_reg <= dpjaf_pkg::ELBOW_MAX ||
                         out_angle_reg == dpjaf_pkg::DISAGREE_CODE),
        "angle code out of range")
    `DPJAF_ASSERT(a_mid_held,
        (mid_vld_reg && !out_adv) |=>
            (mid_vld_reg && $stable(mid_pot_reg) && $stable(mid_bad_reg)),
        "fusion stage lost an item under stall")
    `DPJAF_ASSERT(a_in_held,
        (in_vld_reg && !mid_adv) |=> (in_vld_reg && $stable(va_reg) && $stable(vb_reg)),
        "input stage lost an item under stall")

endmodule

### hdl/dpjaf_angle.sv
// One potentiometer's angle: 131/100 scaling, calibration offset, wrap and dead zone.
module dpjaf_angle (
    input  dpjaf_pkg::sensor_t        side,
    input  logic [7:0]                value,
    input  logic [8:0]                zero_offset,
    output dpjaf_pkg::sensor_status_t status
);

    logic [15:0]        scaled;
    logic [15:0]        zero_x100;
    logic [27:0]        quo_lo_prod;
    logic [27:0]        quo_hi_prod;
    logic [8:0]         quo_floor;
    logic [8:0]         quo_ceil;
    logic signed [10:0] zero_s;
    logic signed [10:0] floor_s;
    logic signed [10:0] ceil_s;
    logic signed [10:0] raw;
    logic signed [10:0] wrapped;

    // Both sides of the sign test, in hundredths of a degree.
    assign scaled    = 16'(value) * 16'(dpjaf_pkg::SCALE_NUM);
    assign zero_x100 = 16'(zero_offset) * 16'(dpjaf_pkg::SCALE_DEN);

    // Floor and ceiling of 131*v/100 through a reciprocal multiply.
    assign quo_lo_prod = 28'(value) * 28'(dpjaf_pkg::QUO_RECIP);
    assign quo_hi_prod = quo_lo_prod + 28'(dpjaf_pkg::QUO_CEIL_ADD);
    assign quo_floor   = quo_lo_prod[dpjaf_pkg::DIV100_SHIFT +: 9];
    assign quo_ceil    = quo_hi_prod[dpjaf_pkg::DIV100_SHIFT +: 9];

    assign zero_s  = $signed({2'b00, zero_offset});
    assign floor_s = $signed({2'b00, quo_floor});
    assign ceil_s  = $signed({2'b00, quo_ceil});

    // Truncation toward zero picks the floor or the ceiling by the sign of the difference.
    always_comb begin
        unique case (side)
            dpjaf_pkg::SENSOR_A: begin
                raw = (scaled <= zero_x100) ? (zero_s - ceil_s) : (zero_s - floor_s);
            end
            dpjaf_pkg::SENSOR_B: begin
                raw = (scaled >= zero_x100) ? (floor_s - zero_s) : (ceil_s - zero_s);
            end
            default: begin
                raw = '0;
            end
        endcase
    end

    // Bring the angle back into range, once only.
    always_comb begin
        priority if (raw < 11'sd0) begin
            wrapped = raw + dpjaf_pkg::FULL_TURN;
        end else if (raw > dpjaf_pkg::FULL_TURN) begin
            wrapped = raw - dpjaf_pkg::FULL_TURN;
        end else begin
            wrapped = raw;
        end
    end

    assign status.angle = wrapped[9:0];
    assign status.dead  = (value < dpjaf_pkg::DEAD_LOW) || (value > dpjaf_pkg::DEAD_HIGH);

endmodule
